// ----- rtl/iemm_pkg.sv -----
// Shared types, constants and register indexes for the extrema mark-and-mean unit.
package iemm_pkg;

  // Default frame limits
  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_VOI  = 2'd2;

  // Configuration reset values
  localparam logic [6:0] ROWS_RST = 7'd64;
  localparam logic [6:0] COLS_RST = 7'd64;
  localparam logic [8:0] VOI_RST  = 9'h1FF;

  // Input modes and result kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic KIND_STAT = 1'b0;
  localparam logic KIND_PIX  = 1'b1;

  localparam logic [7:0] PIX_WHITE = 8'd255;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
    logic       last;
    logic [5:0] row;
    logic [5:0] col;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  drawn_pixel;
    logic [15:0] mean_q8;
    logic [7:0]  min_value;
    logic [7:0]  max_value;
  } out_item_t;

endpackage

// ----- rtl/iemm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module iemm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/iemm_front.sv -----
// Input side: accepts items and holds them in a two-entry queue for the back end.
module iemm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iemm_pkg::in_item_t in_data_i,
  output logic               q_valid_o,
  output iemm_pkg::in_item_t q_item_o,
  input  logic               q_pop_i
);
  import iemm_pkg::*;

  in_item_t   buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= in_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/iemm_back.sv -----
// Back end: frame store, load/read-back, mark, draw, sum and divide sequencer.
module iemm_back #(
  parameter int MAX_ROWS = iemm_pkg::DefMaxRows,
  parameter int MAX_COLS = iemm_pkg::DefMaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          cfg_rows_i,
  input  logic [6:0]          cfg_cols_i,
  input  logic [8:0]          cfg_voi_i,
  input  logic                q_valid_i,
  input  iemm_pkg::in_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iemm_pkg::out_item_t out_data_o
);
  import iemm_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int TW    = AW + 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int ERW   = (RW > 7) ? RW : 7;
  localparam int ECW   = (CW > 7) ? CW : 7;
  localparam int SW    = AW + 9;
  localparam int DW    = SW + 8;
  localparam int NW    = $clog2(DW + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_READ     = 9'b000000010,
    S_MARK     = 9'b000000100,
    S_DRAW_RD  = 9'b000001000,
    S_DRAW_CHK = 9'b000010000,
    S_DRAW_WR  = 9'b000100000,
    S_SUM      = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_RES      = 9'b100000000
  } state_e;

  state_e          st_q;
  logic [7:0]      min_q, max_q;
  logic [TW-1:0]   idx_q, k_q;
  logic            rd_v_q;
  logic [AW-1:0]   rd_a_q;
  logic [RW-1:0]   r_q, rr_q, r1_q;
  logic [CW-1:0]   c_q, cc_q, c0_q, c1_q;
  logic [SW-1:0]   sum_q;
  logic [DW-1:0]   dvd_q;
  logic [TW-1:0]   rem_q;
  logic [NW-1:0]   dcnt_q;
  logic            rb_in_q;
  out_item_t       res_q, out_q;
  logic            out_valid_q;

  // Effective frame size
  logic [ERW-1:0]  rows_x;
  logic [ECW-1:0]  cols_x;
  logic [RW-1:0]   rows;
  logic [CW-1:0]   cols;
  logic [TW-1:0]   total;

  assign rows_x = ERW'(cfg_rows_i);
  assign cols_x = ECW'(cfg_cols_i);
  assign rows = (rows_x == '0) ? RW'(1) :
                (rows_x > ERW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_x);
  assign cols = (cols_x == '0) ? CW'(1) :
                (cols_x > ECW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_x);
  assign total = TW'(TW'(rows) * TW'(cols));

  // RAMs
  logic          fr_we, fr_re, mk_we, mk_re, mk_wdata;
  logic [AW-1:0] fr_waddr, fr_raddr, mk_waddr, mk_raddr;
  logic [7:0]    fr_wdata, fr_rdata;
  logic          mk_rdata;

  iemm_ram #(.WIDTH(8), .DEPTH(Depth)) u_frame (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .re_i(fr_re), .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  iemm_ram #(.WIDTH(1), .DEPTH(Depth)) u_mark (
    .clk_i, .we_i(mk_we), .waddr_i(mk_waddr), .wdata_i(mk_wdata),
    .re_i(mk_re), .raddr_i(mk_raddr), .rdata_o(mk_rdata)
  );

  // Item decode
  logic          is_load, is_read, load_ok, rb_in;
  logic [AW-1:0] rb_addr, draw_addr;
  assign is_load   = (st_q == S_IDLE) && q_valid_i && (q_item_i.mode == MODE_LOAD);
  assign is_read   = (st_q == S_IDLE) && q_valid_i && (q_item_i.mode == MODE_READ);
  assign load_ok   = idx_q < total;
  assign rb_in     = (ERW'(q_item_i.row) < ERW'(rows)) && (ECW'(q_item_i.col) < ECW'(cols));
  assign rb_addr   = AW'(TW'(q_item_i.row) * TW'(cols) + TW'(q_item_i.col));
  assign draw_addr = AW'(TW'(rr_q) * TW'(cols) + TW'(cc_q));
  assign q_pop_o   = (st_q == S_IDLE) && q_valid_i;

  // Mark test on the stored pixel
  logic hit;
  assign hit = (fr_rdata == min_q) || (fr_rdata == max_q) ||
               (!cfg_voi_i[8] && (fr_rdata == cfg_voi_i[7:0]));

  logic k_more;
  assign k_more = k_q < total;

  // Neighborhood bounds of the current pixel
  logic [RW-1:0] r0, r1;
  logic [CW-1:0] c0, c1;
  assign r0 = (r_q != '0) ? r_q - RW'(1) : r_q;
  assign c0 = (c_q != '0) ? c_q - CW'(1) : c_q;
  assign r1 = ((RW+1)'(r_q) + (RW+1)'(1) < (RW+1)'(rows)) ? r_q + RW'(1) : r_q;
  assign c1 = ((CW+1)'(c_q) + (CW+1)'(1) < (CW+1)'(cols)) ? c_q + CW'(1) : c_q;

  // Divider step
  logic [TW:0] trial;
  logic        qbit;
  assign trial = {rem_q, dvd_q[DW-1]};
  assign qbit  = trial >= {1'b0, total};

  // RAM port control
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = idx_q[AW-1:0];
    fr_wdata = q_item_i.pixel;
    fr_re    = 1'b0;
    fr_raddr = k_q[AW-1:0];
    mk_we    = 1'b0;
    mk_waddr = rd_a_q;
    mk_wdata = hit;
    mk_re    = 1'b0;
    mk_raddr = k_q[AW-1:0];
    case (st_q)
      S_IDLE: begin
        fr_we    = is_load && load_ok;
        fr_re    = is_read && rb_in;
        fr_raddr = rb_addr;
      end
      S_MARK: begin
        fr_re = k_more;
        mk_we = rd_v_q;
      end
      S_DRAW_RD: mk_re = k_more;
      S_DRAW_WR: begin
        fr_we    = 1'b1;
        fr_waddr = draw_addr;
        fr_wdata = PIX_WHITE;
      end
      S_SUM: fr_re = k_more;
      default: ;
    endcase
  end

  // Output register
  logic out_free, res_fire;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign res_fire    = (st_q == S_RES) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
      out_q       <= res_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      min_q   <= 8'd255;
      max_q   <= 8'd0;
      idx_q   <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      rd_a_q  <= '0;
      r_q     <= '0;
      c_q     <= '0;
      rr_q    <= '0;
      cc_q    <= '0;
      r1_q    <= '0;
      c0_q    <= '0;
      c1_q    <= '0;
      sum_q   <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dcnt_q  <= '0;
      rb_in_q <= 1'b0;
      res_q   <= '0;
    end else begin
      // Read data is valid in the cycle after a mark or sum read
      rd_v_q <= ((st_q == S_MARK) || (st_q == S_SUM)) && k_more;
      case (st_q)
        S_IDLE: begin
          if (is_load) begin
            if (load_ok) begin
              idx_q <= idx_q + TW'(1);
              if (q_item_i.pixel < min_q) min_q <= q_item_i.pixel;
              if (q_item_i.pixel > max_q) max_q <= q_item_i.pixel;
            end
            if (q_item_i.last) begin
              // Last pixel may still update min/max this cycle; mark starts next
              k_q  <= '0;
              st_q <= S_MARK;
            end
          end else if (is_read) begin
            rb_in_q <= rb_in;
            st_q    <= S_READ;
          end
        end
        S_READ: begin
          res_q <= out_item_t'{KIND_PIX, (rb_in_q ? fr_rdata : 8'd0), 16'd0, 8'd0, 8'd0};
          st_q  <= S_RES;
        end
        S_MARK: begin
          if (k_more) begin
            rd_a_q <= k_q[AW-1:0];
            k_q    <= k_q + TW'(1);
          end else if (!rd_v_q) begin
            k_q  <= '0;
            r_q  <= '0;
            c_q  <= '0;
            st_q <= S_DRAW_RD;
          end
        end
        S_DRAW_RD: begin
          if (k_more) begin
            st_q <= S_DRAW_CHK;
          end else begin
            k_q   <= '0;
            sum_q <= '0;
            st_q  <= S_SUM;
          end
        end
        S_DRAW_CHK, S_DRAW_WR: begin
          if ((st_q == S_DRAW_CHK) && mk_rdata) begin
            rr_q <= r0;
            cc_q <= c0;
            r1_q <= r1;
            c0_q <= c0;
            c1_q <= c1;
            st_q <= S_DRAW_WR;
          end else if ((st_q == S_DRAW_WR) && !((cc_q == c1_q) && (rr_q == r1_q))) begin
            if (cc_q == c1_q) begin
              rr_q <= rr_q + RW'(1);
              cc_q <= c0_q;
            end else begin
              cc_q <= cc_q + CW'(1);
            end
          end else begin
            // Advance to the next pixel in raster order
            k_q <= k_q + TW'(1);
            if ((CW+1)'(c_q) + (CW+1)'(1) == (CW+1)'(cols)) begin
              c_q <= '0;
              r_q <= r_q + RW'(1);
            end else begin
              c_q <= c_q + CW'(1);
            end
            st_q <= S_DRAW_RD;
          end
        end
        S_SUM: begin
          if (rd_v_q) sum_q <= sum_q + SW'(fr_rdata);
          if (k_more) begin
            k_q <= k_q + TW'(1);
          end else if (!rd_v_q) begin
            dvd_q  <= {sum_q, 8'd0};
            rem_q  <= '0;
            dcnt_q <= NW'(DW);
            st_q   <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_q != '0) begin
            rem_q  <= qbit ? TW'(trial - {1'b0, total}) : TW'(trial);
            dvd_q  <= {dvd_q[DW-2:0], qbit};
            dcnt_q <= dcnt_q - NW'(1);
          end else begin
            res_q.kind        <= KIND_STAT;
            res_q.drawn_pixel <= 8'd0;
            res_q.mean_q8     <= dvd_q[15:0];
            res_q.min_value   <= min_q;
            res_q.max_value   <= max_q;
            min_q             <= 8'd255;
            max_q             <= 8'd0;
            idx_q             <= '0;
            st_q              <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/image_extrema_mark_and_mean_unit.sv -----
// Top level of the extrema mark-and-mean unit: configuration registers and wiring.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries loads and read-backs.
// A load writes the next pixel of the frame in raster order; the load flagged
// last starts frame processing and yields one statistics transfer (mean in Q8,
// min, max). A read-back yields one transfer with the drawn pixel.
// Output channel (out_valid_o / out_stall_i / out_data_o) is registered.
// Configuration: cfg_valid_i / cfg_ready_o with index and data; write only when idle.
// Processing: after the last pixel the back end runs mark, draw (one write per
// drawn neighbor cell, at most 9 per mark), sum and a bit-serial divide, then
// loads the output register. A read-back reads the frame RAM, then loads it.
// A two-entry queue takes input while the back end works.
// Reset sets rows and cols to 64, value of interest to -1 (off), min 255, max 0.
// Frame RAM contents are undefined after reset; no clearing pass is run.
// While the receiver stalls the result is held and the back end waits; the
// queue fills and then the input stalls.
module image_extrema_mark_and_mean_unit #(
  parameter int MAX_ROWS = iemm_pkg::DefMaxRows,
  parameter int MAX_COLS = iemm_pkg::DefMaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iemm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iemm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [8:0]          cfg_data_i
);
  import iemm_pkg::*;

  logic [6:0] rows_q, cols_q;
  logic [8:0] voi_q;
  logic       q_valid, q_pop;
  in_item_t   q_item;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      voi_q  <= VOI_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS: rows_q <= cfg_data_i[6:0];
        REG_COLS: cols_q <= cfg_data_i[6:0];
        REG_VOI:  voi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  iemm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  iemm_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk_i, .rst_ni,
    .cfg_rows_i(rows_q), .cfg_cols_i(cols_q), .cfg_voi_i(voi_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
